@@ rtl/rbg_pkg.sv @@
// Shared constants, payload types and helper functions for the restart backoff gate.
package rbg_pkg;

   localparam int HISTORY_DEPTH  = 32;
   localparam int TIME_BITS      = 32;
   localparam int SHIFT_LIMIT    = 16;
   localparam int CNT_BITS       = $clog2(HISTORY_DEPTH + 1);
   localparam int POS_BITS       = $clog2(HISTORY_DEPTH);
   localparam int SHIFT_BITS     = $clog2(SHIFT_LIMIT + 1);
   localparam int BASE_GAP_BITS  = 16;
   localparam int GAP_BITS       = 17;
   localparam int CMP_BITS       = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;
   localparam int SUM_BITS       = CMP_BITS + 1;
   localparam int SHIFTED_BITS   = BASE_GAP_BITS + SHIFT_LIMIT;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_GAP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_GAP  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW   = 2'd2;

   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   typedef logic [TIME_BITS-1:0] stamp_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [31:0] earliest_time;
      logic [5:0]  recent_count;
   } rsp_type;

   typedef struct packed {
      logic      valid;
      stamp_type stamp;
   } cell_type;

   // True when the stamp lies more than window seconds before now.
   function automatic logic too_old(stamp_type now, stamp_type stamp,
                                    logic [GAP_BITS-1:0] window);
      logic [CMP_BITS-1:0] diff;
      diff = CMP_BITS'(now - stamp);
      return (now >= stamp) && (diff > CMP_BITS'(window));
   endfunction

endpackage

@@ rtl/rbg_cell.sv @@
// One history cell: a timestamp and its occupied flag, loaded from the neighbor on a shift.
module rbg_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  rbg_pkg::cell_type cell_in,
   output rbg_pkg::cell_type cell_out
);
   import rbg_pkg::*;

   logic      valid_ff;
   stamp_type stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         stamp_ff <= cell_in.stamp;
      end
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.stamp = stamp_ff;

endmodule

@@ rtl/rbg_backoff.sv @@
// Backoff gap computation: shifted and capped gap, then saturating sum against now.
module rbg_backoff (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic [rbg_pkg::CNT_BITS-1:0]           count,
   input  logic [rbg_pkg::BASE_GAP_BITS-1:0]      base_gap,
   input  logic [rbg_pkg::GAP_BITS-1:0]           max_gap,
   input  rbg_pkg::stamp_type                     newest,
   input  rbg_pkg::stamp_type                     now,
   output rbg_pkg::stamp_type                     earliest
);
   import rbg_pkg::*;

   logic [CNT_BITS-1:0]     count_m1;
   logic [SHIFT_BITS-1:0]   shift_amt;
   logic [SHIFTED_BITS-1:0] shifted;
   logic [GAP_BITS-1:0]     gap_in;

   logic [GAP_BITS-1:0]     gap_ff;
   stamp_type               newest_ff;
   stamp_type               now_ff;
   logic                    none_ff;

   logic [SUM_BITS-1:0]     sum;
   stamp_type               capped;

   always_comb begin
      count_m1 = count - 1'b1;
      if (32'(count_m1) > 32'(SHIFT_LIMIT)) begin
         shift_amt = SHIFT_BITS'(SHIFT_LIMIT);
      end else begin
         shift_amt = SHIFT_BITS'(count_m1);
      end
      shifted = SHIFTED_BITS'(base_gap) << shift_amt;
      if (shifted > SHIFTED_BITS'(max_gap)) begin
         gap_in = max_gap;
      end else begin
         gap_in = shifted[GAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gap_ff    <= gap_in;
         newest_ff <= newest;
         now_ff    <= now;
         none_ff   <= (count == '0);
      end
   end

   always_comb begin
      sum = SUM_BITS'(newest_ff) + SUM_BITS'(gap_ff);
      if (sum[SUM_BITS-1:TIME_BITS] != '0) begin
         capped = {TIME_BITS{1'b1}};
      end else begin
         capped = sum[TIME_BITS-1:0];
      end
      if (none_ff || (now_ff >= capped)) begin
         earliest = now_ff;
      end else begin
         earliest = capped;
      end
   end

endmodule

@@ rtl/restart_backoff_gate.sv @@
// Restart gate top level: history cell chain, sequencer, configuration and result register.
// A record transfer shifts the new stamp in at the head and then makes one full rotation of
// the cell chain; a query transfer makes the rotation and then the ST_GAP and ST_SUM steps.
// The rotation passes every stored timestamp past the evaluation point at the tail.
// One item is in work at a time; a new item is taken while a result waits on rsp_stall.
// Synchronous reset empties the history and loads base_gap 1, max_gap 300, window 600.
module restart_backoff_gate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rbg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rbg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_enable,
   input  logic [rbg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rbg_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import rbg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SHIFT  = 5'b00010,
      ST_ROTATE = 5'b00100,
      ST_GAP    = 5'b01000,
      ST_SUM    = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [BASE_GAP_BITS-1:0]  base_gap_ff;
   logic [GAP_BITS-1:0]       max_gap_ff;
   logic [GAP_BITS-1:0]       window_ff;

   logic                      kind_ff;
   stamp_type                 now_ff;
   logic [POS_BITS-1:0]       pos_ff, pos_in;
   logic [CNT_BITS-1:0]       entry_count_ff, entry_count_in;
   logic [CNT_BITS-1:0]       recent_ff, recent_in;
   logic                      dropping_ff, dropping_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   cell_type                  chain [HISTORY_DEPTH];
   cell_type                  head_in;
   cell_type                  tail;
   logic                      shift_en;
   logic                      tail_old;
   logic                      drop;
   logic                      rsp_free;
   logic                      accept;
   stamp_type                 earliest;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_gap_ff <= BASE_GAP_BITS'(1);
         max_gap_ff  <= GAP_BITS'(300);
         window_ff   <= GAP_BITS'(600);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_GAP: base_gap_ff <= csr_write_data[BASE_GAP_BITS-1:0];
            CSR_MAX_GAP:  max_gap_ff  <= csr_write_data[GAP_BITS-1:0];
            CSR_WINDOW:   window_ff   <= csr_write_data[GAP_BITS-1:0];
            default:      ;
         endcase
      end
   end

   // Cell chain: cell 0 holds the newest entry, occupied cells are contiguous from cell 0.
   for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
      cell_type link;
      if (k == 0) begin : g_head
         assign link = head_in;
      end else begin : g_body
         assign link = chain[k-1];
      end
      rbg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .cell_in  (link),
         .cell_out (chain[k])
      );
   end

   assign tail     = chain[HISTORY_DEPTH-1];
   assign tail_old = too_old(now_ff, tail.stamp, window_ff);
   // During a record rotation the oldest entries reach the tail first; drop them
   // until the first one that is still recent.
   assign drop     = (state_ff == ST_ROTATE) && (kind_ff == KIND_RECORD) &&
                     dropping_ff && tail.valid && tail_old;
   assign shift_en = (state_ff == ST_SHIFT) || (state_ff == ST_ROTATE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      if (state_ff == ST_SHIFT) begin
         head_in.valid = 1'b1;
         head_in.stamp = now_ff;
      end else begin
         head_in.valid = tail.valid && !drop;
         head_in.stamp = tail.stamp;
      end
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      entry_count_in = entry_count_ff;
      recent_in      = recent_ff;
      dropping_in    = dropping_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in      = '0;
               recent_in   = '0;
               dropping_in = 1'b1;
               state_in    = (req_data.kind == KIND_RECORD) ? ST_SHIFT : ST_ROTATE;
            end
         end
         ST_SHIFT: begin
            if (entry_count_ff != CNT_BITS'(HISTORY_DEPTH)) begin
               entry_count_in = entry_count_ff + 1'b1;
            end
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (kind_ff == KIND_RECORD) begin
               if (drop) begin
                  entry_count_in = entry_count_ff - 1'b1;
               end else if (tail.valid) begin
                  dropping_in = 1'b0;
               end
            end else if (tail.valid && !tail_old) begin
               recent_in = recent_ff + 1'b1;
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_BITS'(HISTORY_DEPTH - 1)) begin
               state_in = (kind_ff == KIND_RECORD) ? ST_IDLE : ST_GAP;
            end
         end
         ST_GAP: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         entry_count_ff <= '0;
         recent_ff      <= '0;
         dropping_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         entry_count_ff <= entry_count_in;
         recent_ff      <= recent_in;
         dropping_ff    <= dropping_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.kind;
         now_ff  <= TIME_BITS'(req_data.now);
      end
   end

   rbg_backoff u_backoff (
      .clock     (clock),
      .load      (state_ff == ST_GAP),
      .count     (recent_ff),
      .base_gap  (base_gap_ff),
      .max_gap   (max_gap_ff),
      .newest    (chain[0].stamp),
      .now       (now_ff),
      .earliest  (earliest)
   );

   // Result register: holds a finished result until the consumer takes the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_SUM) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SUM) && rsp_free) begin
         rsp_data_ff.earliest_time <= 32'(earliest);
         if (32'(recent_ff) > 32'(63)) begin
            rsp_data_ff.recent_count <= 6'd63;
         end else begin
            rsp_data_ff.recent_count <= 6'(recent_ff);
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
